[rtl/core/swm_pkg.sv]
package swm_pkg;

  // Fixed field widths.
  localparam int DATA_W = 32;
  localparam int WIN_W  = 7;

  // Default store depth (largest supported window).
  localparam int MAX_WINDOW_DEF = 64;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes (byte address is 4 * index).
  localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

  localparam logic [WIN_W-1:0] WINDOW_LENGTH_RST = WIN_W'(1);

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last_sample;
  } swm_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] max_value;
    logic                     last_result;
  } swm_out_t;

  // Control handed from the top level to every cell.
  typedef struct packed {
    logic                     shift_en;
    logic signed [DATA_W-1:0] sample;
  } swm_cell_ctrl_t;

endpackage

[rtl/core/swm_cell.sv]
module swm_cell
  import swm_pkg::*;
(
  input  logic                     clk,
  input  swm_cell_ctrl_t           ctrl,
  input  logic signed [DATA_W-1:0] prev_max,
  output logic signed [DATA_W-1:0] run_max
);

  logic signed [DATA_W-1:0] run_max_r;
  logic signed [DATA_W-1:0] run_max_nxt;

  // The running maximum moves one age step along the row and absorbs the new sample.
  assign run_max_nxt = (prev_max > ctrl.sample) ? prev_max : ctrl.sample;

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      run_max_r <= run_max_nxt;
    end
  end

  assign run_max = run_max_r;

endmodule

[rtl/core/sliding_window_max_unit.sv]
// Streaming maximum over the most recent window_length signed samples.
//
// Samples enter on the in_ channel and results leave on the out_ channel; on
// both, a transfer happens at a rising edge where valid is high and stall is
// low. Every accepted sample yields at most one result: once window_length
// samples of the current sequence have arrived, each sample gives the window
// maximum. A sample marked last_sample ends the sequence; its result carries
// last_result and the sequence state is cleared afterwards.
//
// A result shows on the out_ channel in the cycle after its sample transfer.
// The block takes one sample per cycle while in_stall is low; that rate is
// set by the row of cells, which all update in the same cycle, and by the
// single output register. While the receiver stalls a waiting result,
// in_stall is raised and the result holds steady.
//
// After reset window_length is 1, no result is pending and the sequence is
// empty. window_length is written through the cfg_ APB port at address 0 and
// must only be changed while no sample is in flight.
module sliding_window_max_unit
  import swm_pkg::*;
#(
  parameter int MaxWindow = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  swm_in_t               in_data,

  output logic                  out_valid,
  input  logic                  out_stall,
  output swm_out_t              out_data,

  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int IW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int CW = $clog2(MaxWindow + 1);
  localparam int WW = (CW > WIN_W) ? CW : WIN_W;

  // Cell i holds the maximum of the samples of age 0 through i. The live
  // span is the number of recent samples that have not expired; it never
  // grows past the window in force when a sample arrives, and expired samples
  // stay expired even if the window later grows. The window maximum is then
  // the running maximum held by the oldest live cell.

  logic [WIN_W-1:0]         win_r;
  logic [CW-1:0]            live_r;
  logic [CW-1:0]            live_nxt;
  logic [CW-1:0]            seen_r;
  logic [CW-1:0]            seen_nxt;
  logic                     out_valid_r;
  swm_out_t                 out_data_r;

  logic                     cfg_wr;
  logic                     in_xfer;
  logic [WW-1:0]            win_eff;
  logic [WW:0]              live_inc;
  logic [IW-1:0]            sel_idx;
  logic signed [DATA_W-1:0] cand;
  logic signed [DATA_W-1:0] result;
  logic                     produce;
  swm_cell_ctrl_t           cell_ctrl;
  logic signed [DATA_W-1:0] cell_max [MaxWindow];

  // Configuration port. Writes complete in the access phase; no wait states.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WINDOW_LENGTH_RST;
    end else if (cfg_wr && (cfg_paddr[CFG_ADDR_W-1] == REG_WINDOW_LENGTH)) begin
      win_r <= cfg_pwdata[WIN_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_W-1] == REG_WINDOW_LENGTH) begin
      cfg_prdata = CFG_DATA_W'(win_r);
    end
  end

  // A window of zero acts as one; anything beyond the store depth saturates.
  always_comb begin
    if (win_r == '0) begin
      win_eff = WW'(1);
    end else if (WW'(win_r) > WW'(MaxWindow)) begin
      win_eff = WW'(MaxWindow);
    end else begin
      win_eff = WW'(win_r);
    end
  end

  // A new sample is taken whenever the output register is free or drains now.
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  // Live span after this sample: one more than before, capped by the window.
  always_comb begin
    live_inc = (WW + 1)'(live_r) + (WW + 1)'(1);
    if (live_inc > (WW + 1)'(win_eff)) begin
      live_nxt = CW'(win_eff);
    end else begin
      live_nxt = CW'(live_inc);
    end
  end

  assign seen_nxt = (seen_r == CW'(MaxWindow)) ? seen_r : seen_r + CW'(1);
  assign produce  = WW'(seen_nxt) >= win_eff;

  // The oldest live sample after this step was held at age live_nxt - 2
  // before it, so that cell's maximum plus the new sample covers the window.
  assign sel_idx = IW'(live_nxt - CW'(2));
  assign cand    = cell_max[sel_idx];

  always_comb begin
    result = in_data.sample;
    if ((live_nxt >= CW'(2)) && (cand > in_data.sample)) begin
      result = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      seen_r <= '0;
    end else if (in_xfer) begin
      if (in_data.last_sample) begin
        live_r <= '0;
        seen_r <= '0;
      end else begin
        live_r <= live_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  // The row of cells. Cell 0 takes the new sample; every other cell takes the
  // maximum of its younger neighbor and the new sample.
  assign cell_ctrl.shift_en = in_xfer;
  assign cell_ctrl.sample   = in_data.sample;

  for (genvar gi = 0; gi < MaxWindow; gi++) begin : g_cell
    if (gi == 0) begin : g_head
      swm_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .prev_max (in_data.sample),
        .run_max  (cell_max[gi])
      );
    end else begin : g_body
      swm_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .prev_max (cell_max[gi-1]),
        .run_max  (cell_max[gi])
      );
    end
  end

  // Output register. It is loaded by every sample transfer; a sample that
  // gives no result simply leaves it empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= produce;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r.max_value   <= result;
      out_data_r.last_result <= in_data.last_sample;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The live span never exceeds the store depth.
  a_live_bound : assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CW'(MaxWindow))
    else $error("live span beyond store depth");

  // Live samples are always a subset of the samples seen in this sequence.
  a_live_le_seen : assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= seen_r)
    else $error("live span exceeds sample count");

  // A sample marked last clears the sequence state.
  a_last_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.last_sample) |=> (live_r == '0) && (seen_r == '0))
    else $error("sequence state not cleared after last sample");

  // A result appears only as the answer to a sample transfer.
  a_out_from_in : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_xfer))
    else $error("result without a sample transfer");

endmodule
